>>> sv/dnc_pkg.sv
// ----------------------------------------------------------------------------
// dnc_pkg: shared definitions for the delimiter nesting checker
// Character codes, symbol and fault codes, stack sizing and the operation
// record that travels from the classifier to the stack engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dnc_pkg;

  // Stack sizing
  localparam int STACK_DEPTH = 64;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

  // Operation queue sizing (power of two, pointers wrap)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Characters
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LSQ    = 8'h5B;
  localparam logic [7:0] CH_RSQ    = 8'h5D;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  // Symbol codes
  localparam logic [1:0] SYM_PAREN   = 2'd0;
  localparam logic [1:0] SYM_SQUARE  = 2'd1;
  localparam logic [1:0] SYM_CURLY   = 2'd2;
  localparam logic [1:0] SYM_COMMENT = 2'd3;

  // Pending marker codes
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_SLASH = 2'd1;
  localparam logic [1:0] PEND_STAR  = 2'd2;

  // Fault codes
  localparam logic [1:0] FLT_NONE     = 2'd0;
  localparam logic [1:0] FLT_CLOSER   = 2'd1;
  localparam logic [1:0] FLT_MISMATCH = 2'd2;
  localparam logic [1:0] FLT_OVERFLOW = 2'd3;

  // Stack actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_PUSH = 2'd1;
  localparam logic [1:0] ACT_POP  = 2'd2;

  typedef struct packed {
    logic [1:0] act;
    logic [1:0] sym;
    logic       last;
  } op_t;

endpackage

`default_nettype wire

>>> sv/delimiter_nesting_checker.sv
// ----------------------------------------------------------------------------
// delimiter_nesting_checker: streaming check of (), [], {} and comment nesting
// Bytes enter on the in_ stream; one verdict per text leaves on the out_ stream.
//
// Usage:
//   - Send text one byte per transfer on in_tdata, with in_tlast high on the
//     last byte of a text. Only that byte produces a result transfer.
//   - out_tdata carries balanced, fault kind and fault symbol of the text.
//   - Throughput is one byte per cycle while the queue has room: the stack
//     top sits in a register and the next-to-top entry is read ahead from
//     the stack memory, so each byte costs a single push, pop or compare
//     in the stack engine. The last byte's operation passes the queue and
//     then the output register before out_tvalid rises.
//   - A four-entry queue separates the classifier from the stack engine; when
//     the receiver stalls, the verdict holds in the output register, the
//     engine stops, and in_tready drops once the queue fills.
//   - Reset (synchronous, rst_n low) empties the stack, clears the pending
//     marker and the latched fault; no clearing pass is needed. After each
//     verdict the checker returns to the same state on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module delimiter_nesting_checker import dnc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] text_byte
  input  wire logic       in_tlast,   // final_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [0] balanced, [2:1] fault_kind,
                                      // [4:3] fault_symbol, [7:5] zero
);

  logic fr_valid;
  op_t  fr_op;
  logic q_ready;
  logic bk_valid;
  op_t  bk_op;
  logic bk_ready;

  // Classify incoming bytes
  dnc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_tvalid),
    .text_byte  (in_tdata),
    .final_byte (in_tlast),
    .q_ready    (q_ready),
    .byte_ready (in_tready),
    .op_valid   (fr_valid),
    .op         (fr_op)
  );

  // Decouple classifier and stack engine
  dnc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq_valid (fr_valid),
    .enq_op    (fr_op),
    .enq_ready (q_ready),
    .deq_valid (bk_valid),
    .deq_op    (bk_op),
    .deq_ready (bk_ready)
  );

  // Run the stack and deliver verdicts
  dnc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (bk_valid),
    .op        (bk_op),
    .op_ready  (bk_ready),
    .res_valid (out_tvalid),
    .res_data  (out_tdata),
    .res_ready (out_tready)
  );

endmodule

`default_nettype wire

>>> sv/dnc_front.sv
// ----------------------------------------------------------------------------
// dnc_front: byte classifier
// Tracks a pending slash or star and turns each byte into a push, pop or
// nothing. Only stack operations and end-of-text markers enter the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dnc_front import dnc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_valid,
  input  wire logic [7:0] text_byte,
  input  wire logic       final_byte,
  input  wire logic       q_ready,
  output logic            byte_ready,
  output logic            op_valid,
  output op_t             op
);

  logic [1:0] pend_r;
  logic [1:0] pend_nxt;
  logic [1:0] pend_scan;
  logic       take;

  assign byte_ready = q_ready;
  assign take       = byte_valid && q_ready;

  // Classify the byte against the held marker
  always_comb begin
    op.act    = ACT_NONE;
    op.sym    = SYM_PAREN;
    op.last   = final_byte;
    pend_scan = PEND_NONE;
    if (pend_r == PEND_SLASH && text_byte == CH_STAR) begin
      op.act = ACT_PUSH;
      op.sym = SYM_COMMENT;
    end else if (pend_r == PEND_STAR && text_byte == CH_SLASH) begin
      op.act = ACT_POP;
      op.sym = SYM_COMMENT;
    end else begin
      case (text_byte)
        CH_LPAREN: begin op.act = ACT_PUSH; op.sym = SYM_PAREN;  end
        CH_LSQ:    begin op.act = ACT_PUSH; op.sym = SYM_SQUARE; end
        CH_LCURLY: begin op.act = ACT_PUSH; op.sym = SYM_CURLY;  end
        CH_RPAREN: begin op.act = ACT_POP;  op.sym = SYM_PAREN;  end
        CH_RSQ:    begin op.act = ACT_POP;  op.sym = SYM_SQUARE; end
        CH_RCURLY: begin op.act = ACT_POP;  op.sym = SYM_CURLY;  end
        CH_SLASH:  pend_scan = PEND_SLASH;
        CH_STAR:   pend_scan = PEND_STAR;
        default:   pend_scan = PEND_NONE;
      endcase
    end
  end

  // Drop plain bytes unless they end the text
  assign op_valid = take && (op.act != ACT_NONE || final_byte);

  // Advance the pending marker; the end of text clears it
  always_comb begin
    pend_nxt = pend_r;
    if (take) begin
      pend_nxt = final_byte ? PEND_NONE : pend_scan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PEND_NONE;
    end else begin
      pend_r <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/dnc_queue.sv
// ----------------------------------------------------------------------------
// dnc_queue: operation queue
// Short register queue between the classifier and the stack engine.
// ----------------------------------------------------------------------------
`default_nettype none

module dnc_queue import dnc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic enq_valid,
  input  wire op_t  enq_op,
  output logic      enq_ready,
  output logic      deq_valid,
  output op_t       deq_op,
  input  wire logic deq_ready
);

  op_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_enq, do_deq;

  assign enq_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign deq_valid = (cnt_r != '0);
  assign deq_op    = slot_r[rd_ptr_r];
  assign do_enq    = enq_valid && enq_ready;
  assign do_deq    = deq_valid && deq_ready;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_enq ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_deq ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_enq && !do_deq) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!do_enq && do_deq) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold the payload in the slot being written
  always_ff @(posedge clk) begin
    if (do_enq) begin
      slot_r[wr_ptr_r] <= enq_op;
    end
  end

endmodule

`default_nettype wire

>>> sv/dnc_back.sv
// ----------------------------------------------------------------------------
// dnc_back: stack engine and verdict register
// Keeps the top symbol in a register and the rest of the stack in a memory
// whose next-to-top entry is read ahead, so a pop needs no memory read to find the new top.
// ----------------------------------------------------------------------------
`default_nettype none

module dnc_back import dnc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       op_valid,
  input  wire op_t        op,
  output logic            op_ready,
  output logic            res_valid,
  output logic [7:0]      res_data,
  input  wire logic       res_ready
);

  logic [1:0]        stack_mem [STACK_DEPTH];
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [1:0]        top_r, top_nxt;
  logic [1:0]        fkind_r, fkind_nxt;
  logic [1:0]        fsym_r, fsym_nxt;
  logic [1:0]        second_r;
  logic              byp_hit_r;
  logic [1:0]        byp_data_r;
  logic [1:0]        second;
  logic              we;
  logic [ADDR_W-1:0] wa, ra;
  logic              take;
  logic              out_valid_r;
  logic [7:0]        out_data_r;
  logic [7:0]        verdict;

  assign op_ready  = !out_valid_r || res_ready;
  assign take      = op_valid && op_ready;
  assign second    = byp_hit_r ? byp_data_r : second_r;
  assign res_valid = out_valid_r;
  assign res_data  = out_data_r;

  // Apply one stack operation and form the verdict
  always_comb begin
    level_nxt = level_r;
    top_nxt   = top_r;
    fkind_nxt = fkind_r;
    fsym_nxt  = fsym_r;
    we        = 1'b0;
    wa        = ADDR_W'(level_r - LVL_W'(1));
    verdict   = '0;
    if (take) begin
      if (fkind_r == FLT_NONE) begin
        case (op.act)
          ACT_PUSH: begin
            if (level_r == LVL_W'(STACK_DEPTH)) begin
              fkind_nxt = FLT_OVERFLOW;
              fsym_nxt  = op.sym;
            end else begin
              we        = (level_r != '0);
              top_nxt   = op.sym;
              level_nxt = level_r + LVL_W'(1);
            end
          end
          ACT_POP: begin
            if (level_r == '0) begin
              fkind_nxt = FLT_CLOSER;
              fsym_nxt  = op.sym;
            end else if (top_r != op.sym) begin
              fkind_nxt = FLT_MISMATCH;
              fsym_nxt  = top_r;
            end else begin
              top_nxt   = second;
              level_nxt = level_r - LVL_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (op.last) begin
        if (fkind_nxt != FLT_NONE) begin
          verdict = {3'b000, fsym_nxt, fkind_nxt, 1'b0};
        end else if (level_nxt != '0) begin
          verdict = {3'b000, top_nxt, FLT_MISMATCH, 1'b0};
        end else begin
          verdict = 8'h01;
        end
        level_nxt = '0;
        fkind_nxt = FLT_NONE;
        fsym_nxt  = SYM_PAREN;
      end
    end
    ra = ADDR_W'(level_nxt - LVL_W'(2));
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      fkind_r     <= FLT_NONE;
      fsym_r      <= SYM_PAREN;
      out_valid_r <= 1'b0;
    end else begin
      level_r  <= level_nxt;
      fkind_r  <= fkind_nxt;
      fsym_r   <= fsym_nxt;
      if (take && op.last) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (take && op.last) begin
      out_data_r <= verdict;
    end
  end

  // Stack memory: spill the old top on push, read the next-to-top ahead
  always_ff @(posedge clk) begin
    if (we) begin
      stack_mem[wa] <= top_r;
    end
    second_r   <= stack_mem[ra];
    byp_hit_r  <= we && (wa == ra);
    byp_data_r <= top_r;
  end

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the delimiter nesting checker
// Streams texts into the checker one byte per transfer and keeps a scoreboard
// that tracks the nesting stack, the pending comment marker and the latched
// fault. Every verdict on the out_ stream is checked against the oldest
// predicted one. Directed texts come first, then random texts under changing
// sender and receiver idle rates, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------

module testbench import dnc_pkg::*; ();

  typedef logic [7:0] text_t [$];

  // Verdict as it sits on out_tdata, balanced in bit 0
  typedef struct packed {
    logic [2:0] pad;
    logic [1:0] sym;
    logic [1:0] kind;
    logic       balanced;
  } verdict_t;

  // --------------------------------------------------------------------------
  // Scoreboard: nesting predictor plus the queue of verdicts still due
  // --------------------------------------------------------------------------
  class nesting_scoreboard;
    logic [1:0]  open_syms [STACK_DEPTH];
    int unsigned depth;
    logic [1:0]  pend;
    logic [1:0]  flt_kind;
    logic [1:0]  flt_sym;
    verdict_t    verdicts_due [$];
    int unsigned errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      depth    = 0;
      pend     = PEND_NONE;
      flt_kind = FLT_NONE;
      flt_sym  = SYM_PAREN;
    endfunction

    function void latch(logic [1:0] kind, logic [1:0] sym);
      flt_kind = kind;
      flt_sym  = sym;
    endfunction

    // Push an opener; a full stack latches overflow and stays unchanged
    function void push_sym(logic [1:0] sym);
      if (depth >= STACK_DEPTH) begin
        latch(FLT_OVERFLOW, sym);
      end else begin
        open_syms[depth] = sym;
        depth++;
      end
    endfunction

    // Pop a closer against the top of the stack
    function void close_sym(logic [1:0] sym);
      if (depth == 0) begin
        latch(FLT_CLOSER, sym);
      end else if (open_syms[depth-1] != sym) begin
        latch(FLT_MISMATCH, open_syms[depth-1]);
      end else begin
        depth--;
      end
    endfunction

    // Classify one byte, completing a held marker first
    function void scan(logic [7:0] c);
      logic [1:0] held;
      held = pend;
      pend = PEND_NONE;
      if (held == PEND_SLASH && c == CH_STAR) begin
        push_sym(SYM_COMMENT);
      end else if (held == PEND_STAR && c == CH_SLASH) begin
        close_sym(SYM_COMMENT);
      end else begin
        case (c)
          CH_LPAREN: push_sym(SYM_PAREN);
          CH_LSQ:    push_sym(SYM_SQUARE);
          CH_LCURLY: push_sym(SYM_CURLY);
          CH_RPAREN: close_sym(SYM_PAREN);
          CH_RSQ:    close_sym(SYM_SQUARE);
          CH_RCURLY: close_sym(SYM_CURLY);
          CH_SLASH:  pend = PEND_SLASH;
          CH_STAR:   pend = PEND_STAR;
          default: ;
        endcase
      end
    endfunction

    // Note an accepted input byte; the final byte queues a verdict
    function void note_text(logic [7:0] c, logic last);
      verdict_t v;
      if (flt_kind == FLT_NONE)
        scan(c);
      if (last) begin
        v = '0;
        if (flt_kind != FLT_NONE) begin
          v.kind = flt_kind;
          v.sym  = flt_sym;
        end else if (depth != 0) begin
          v.kind = FLT_MISMATCH;
          v.sym  = open_syms[depth-1];
        end else begin
          v.balanced = 1'b1;
        end
        verdicts_due.push_back(v);
        clear_state();
      end
    endfunction

    // Check an accepted verdict against the oldest one due
    function void check_verdict(logic [7:0] data);
      verdict_t got;
      verdict_t want;
      got = data;
      if (verdicts_due.size() == 0) begin
        $error("verdict %h with none expected", data);
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        if (got.balanced !== want.balanced) begin
          $error("balanced: expected %0d, actual %0d", want.balanced, got.balanced);
          errors++;
        end
        if (got.kind !== want.kind) begin
          $error("fault_kind: expected %0d, actual %0d", want.kind, got.kind);
          errors++;
        end
        if (got.sym !== want.sym) begin
          $error("fault_symbol: expected %0d, actual %0d", want.sym, got.sym);
          errors++;
        end
        if (got.pad !== want.pad) begin
          $error("padding: expected %0d, actual %0d", want.pad, got.pad);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return verdicts_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  wire        in_tready;
  wire        out_tvalid;
  wire  [7:0] out_tdata;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_count    = 0;
  int unsigned items_sent    = 0;

  nesting_scoreboard sb = new();

  initial begin
    forever #4 clk = ~clk;
  end

  delimiter_nesting_checker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] text_byte
    .in_tlast   (in_tlast),    // final_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)    // [0] balanced, [2:1] fault_kind, [4:3] fault_symbol
  );

  // --------------------------------------------------------------------------
  // Text generation
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick_delim();
    case ($urandom_range(7))
      0:       return CH_LPAREN;
      1:       return CH_RPAREN;
      2:       return CH_LSQ;
      3:       return CH_RSQ;
      4:       return CH_LCURLY;
      5:       return CH_RCURLY;
      6:       return CH_SLASH;
      default: return CH_STAR;
    endcase
  endfunction

  function automatic logic [7:0] pick_filler();
    case ($urandom_range(9))
      0:       return CH_SLASH;
      1:       return CH_STAR;
      2:       return 8'($urandom_range(255));
      default: return 8'h61 + 8'($urandom_range(25));
    endcase
  endfunction

  function automatic void add_opener(ref text_t txt, input logic [1:0] sym);
    case (sym)
      SYM_PAREN:  txt.push_back(CH_LPAREN);
      SYM_SQUARE: txt.push_back(CH_LSQ);
      SYM_CURLY:  txt.push_back(CH_LCURLY);
      default: begin
        txt.push_back(CH_SLASH);
        txt.push_back(CH_STAR);
      end
    endcase
  endfunction

  function automatic void add_closer(ref text_t txt, input logic [1:0] sym);
    case (sym)
      SYM_PAREN:  txt.push_back(CH_RPAREN);
      SYM_SQUARE: txt.push_back(CH_RSQ);
      SYM_CURLY:  txt.push_back(CH_RCURLY);
      default: begin
        txt.push_back(CH_STAR);
        txt.push_back(CH_SLASH);
      end
    endcase
  endfunction

  // Nest openers down to the given depth, then close them all in order
  function automatic void build_deep_text(ref text_t txt, input int unsigned levels);
    logic [1:0] opened [$];
    logic [1:0] sym;
    txt = {};
    repeat (levels) begin
      sym = 2'($urandom_range(3));
      opened.push_back(sym);
      add_opener(txt, sym);
    end
    while (opened.size() > 0)
      add_closer(txt, opened.pop_back());
  endfunction

  // Mostly well-formed nesting with filler, some broken, some pure noise
  function automatic void build_text(ref text_t txt);
    logic [1:0]  opened [$];
    logic [1:0]  sym;
    int unsigned cap;
    int unsigned span;
    int unsigned pos;
    txt = {};
    if ($urandom_range(99) < 12) begin
      span = $urandom_range(1, 20);
      repeat (span)
        txt.push_back(($urandom_range(1) == 0) ? 8'($urandom_range(255)) : pick_delim());
    end else begin
      cap  = $urandom_range(1, 8);
      span = $urandom_range(0, 24);
      repeat (span) begin
        case ($urandom_range(3))
          0: begin
            if (opened.size() < cap) begin
              sym = 2'($urandom_range(3));
              opened.push_back(sym);
              add_opener(txt, sym);
            end
          end
          1: begin
            if (opened.size() > 0)
              add_closer(txt, opened.pop_back());
          end
          default: txt.push_back(pick_filler());
        endcase
      end
      while (opened.size() > 0)
        add_closer(txt, opened.pop_back());
      // Break about a third of the texts
      if (txt.size() > 0 && $urandom_range(99) < 35) begin
        pos = $urandom_range(txt.size() - 1);
        case ($urandom_range(3))
          0: txt[pos] = pick_delim();
          1: if (txt.size() > 1) txt.delete(pos);
          2: txt = txt[0:pos];
          default: txt.insert(pos, pick_delim());
        endcase
      end
    end
    if (txt.size() == 0)
      txt.push_back(pick_filler());
  endfunction

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    sb.note_text(c, last);
    items_sent++;
  endtask

  task automatic send_text(input text_t txt);
    foreach (txt[i])
      send_byte(txt[i], i == txt.size() - 1);
  endtask

  // Hold valid low until every verdict due has been taken
  task automatic drain_verdicts();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: check transfers, then pick the next ready level
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready)
        sb.check_verdict(out_tdata);
      if (hold_count > 0) begin
        out_tready <= 1'b0;
        hold_count--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    text_t       txt;
    int unsigned phase_start;
    bit          hold_done;
    bit          drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 23;
    recv_idle_pct = 70;

    // Directed texts
    txt = '{CH_LPAREN, CH_RPAREN};              send_text(txt);  // balanced
    txt = '{CH_RPAREN};                         send_text(txt);  // closer, nothing open
    txt = '{CH_LSQ, CH_RCURLY};                 send_text(txt);  // mismatched top
    txt = '{CH_LCURLY};                         send_text(txt);  // left open
    txt = '{CH_SLASH, CH_STAR, CH_STAR, CH_SLASH}; send_text(txt);  // empty comment
    txt = '{CH_STAR, CH_SLASH};                 send_text(txt);  // comment close alone
    txt = '{CH_SLASH, 8'h78};                   send_text(txt);  // slash not completed
    txt = '{CH_STAR};                           send_text(txt);  // marker held at end
    txt = '{CH_RPAREN, CH_LPAREN};              send_text(txt);  // bytes after fault
    txt = '{8'h00, 8'hFF};                      send_text(txt);  // plain extremes
    txt = '{CH_LSQ, CH_SLASH, CH_STAR, CH_RSQ}; send_text(txt);  // square against comment

    // Random phases with changing idle rates
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 23; recv_idle_pct = 70; end
        1: begin send_idle_pct = 70; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase_start = items_sent;

      // One deep text per phase: full stack, overflow, then near the edge
      case (ph)
        0:       build_deep_text(txt, STACK_DEPTH);
        1:       build_deep_text(txt, STACK_DEPTH + 1);
        default: build_deep_text(txt, $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3));
      endcase
      send_text(txt);

      while (items_sent - phase_start < 330) begin
        build_text(txt);
        send_text(txt);
        if (ph == 0 && !hold_done && items_sent - phase_start > 150) begin
          // Long receiver hold-off while short texts keep coming
          hold_done  = 1'b1;
          hold_count = 80;
          repeat (12) begin
            txt = '{CH_LSQ, CH_RSQ};
            send_text(txt);
          end
        end
        if (ph == 1 && !drain_done && items_sent - phase_start > 160) begin
          drain_done = 1'b1;
          drain_verdicts();
        end
      end
    end

    // Wait for all verdicts, then keep watching for stray verdicts
    drain_verdicts();
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
sv/dnc_pkg.sv
sv/dnc_front.sv
sv/dnc_queue.sv
sv/dnc_back.sv
sv/delimiter_nesting_checker.sv
sim/testbench.sv
